/* hw/rtl/tfkv_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfkv_pkg: shared types and codes
// Command, status and result codes, the cache entry record and the
// sequencer states of the key-value cache.
// ----------------------------------------------------------------------------
package tfkv_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_GET    = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_SCAN   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DUP      = 2'd1,
    ST_MISS     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_ITEM_LIMIT = 2'd0,
    REG_BYTE_LIMIT = 2'd1,
    REG_SCAN_INTVL = 2'd2,
    REG_EVICT_POL  = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXP_MARK,   // mark expired entries in all cells
    S_EXP_POP,    // remove the oldest marked entry, then mark again
    S_ENF_CHECK,  // decide whether a limit is exceeded
    S_ENF_MOD,    // draw mod count, one bit a cycle unless the output stalls
    S_ENF_POP,    // remove the chosen victim
    S_KEY_MARK,   // mark the cell holding the item's key
    S_FIND,       // act on the key match
    S_INS_PUSH,   // append new entry at the tail
    S_DEL_POP,    // remove found entry
    S_FINAL,      // emit final status
    S_EMIT_WAIT   // wait for the output register to drain
  } state_t;

  // one entry; cells are kept oldest-first, so position equals age order
  typedef struct packed {
    logic [63:0] key;
    logic [31:0] value;
    logic [31:0] bytes;
    logic [63:0] expiry;
    logic        fresh;
  } entry_t;

  // control from the sequencer to the cell row
  typedef struct packed {
    logic       clear_marks;
    logic       mark_expired;
    logic       mark_key;
    logic       push;
    logic       pop;
  } cell_ctl_t;

endpackage
`default_nettype wire

/* hw/rtl/ttl_fifo_key_value_cache.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ttl_fifo_key_value_cache: insertion-ordered key-value cache with expiry
// Input items carry a command (insert, get, delete, forced scan) with key,
// value, size, expiry and time fields. Each item yields zero or more removal
// notices (result_kind 0) followed by one final status with last set.
// Entries live in a chain of CAPACITY+1 cells, oldest first; a removal
// shifts the younger entries down one cell. Expired entries are removed
// one at a time, oldest first, with a new expiry mark after each removal;
// a random eviction first reduces the draw mod count bit-serially, while
// an oldest-first eviction removes the head entry. One item is worked on
// at a time; in_ready is low while an item is in progress and while a
// result waits in the output register. Each result sits in an output
// register; while it is held and out_ready is low the sequencer holds and
// no state changes. Reset (rst_n low, synchronous) empties the cache,
// clears the registers and the last scan time. Configuration is to be
// written over the cfg_ APB port only while the block is idle; the block
// itself does not enforce this. Registers: item_limit at 0x00,
// byte_limit 0x08, scan_interval 0x10, evict_policy 0x18.
// ----------------------------------------------------------------------------
module ttl_fifo_key_value_cache
  import tfkv_pkg::*;
#(
  parameter int CAPACITY = 16
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [63:0] in_lookup_key,
  input  wire logic [31:0] in_value_handle,
  input  wire logic [31:0] in_entry_bytes,
  input  wire logic [63:0] in_time_to_live,
  input  wire logic [63:0] in_absolute_expiry,
  input  wire logic [63:0] in_now_time,
  input  wire logic [31:0] in_random_draw,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_result_kind,
  output logic [1:0]       out_status,
  output logic [63:0]      out_out_key,
  output logic [31:0]      out_out_value,
  output logic [31:0]      out_out_bytes,
  output logic [5:0]       out_entries_held,
  output logic             out_last,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int NCELL = CAPACITY + 1;
  localparam int PW    = $clog2(NCELL + 1);

  // ---------------- configuration ----------------
  logic [10:0] item_limit_r;
  logic [35:0] byte_limit_r;
  logic [31:0] scan_interval_r;
  logic        evict_policy_r;
  reg_idx_t    cfg_idx;
  logic        cfg_wr;

  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:3]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_limit_r    <= '0;
      byte_limit_r    <= '0;
      scan_interval_r <= '0;
      evict_policy_r  <= 1'b0;
    end else if (cfg_wr && cfg_paddr[2:0] == 3'd0) begin
      case (cfg_idx)
        REG_ITEM_LIMIT: item_limit_r    <= cfg_pwdata[10:0];
        REG_BYTE_LIMIT: byte_limit_r    <= cfg_pwdata[35:0];
        REG_SCAN_INTVL: scan_interval_r <= cfg_pwdata[31:0];
        REG_EVICT_POL:  evict_policy_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2:0] == 3'd0) begin
      case (cfg_idx)
        REG_ITEM_LIMIT: cfg_prdata = 64'(item_limit_r);
        REG_BYTE_LIMIT: cfg_prdata = 64'(byte_limit_r);
        REG_SCAN_INTVL: cfg_prdata = 64'(scan_interval_r);
        REG_EVICT_POL:  cfg_prdata = 64'(evict_policy_r);
        default:        cfg_prdata = '0;
      endcase
    end
  end

  // ---------------- item registers ----------------
  cmd_t        cmd_r;
  logic [63:0] key_r, now_r;
  logic [31:0] val_r, bytes_r, draw_r;
  logic [63:0] expiry_r;
  logic [63:0] ttl_sum;
  logic        ttl_ovf;

  assign {ttl_ovf, ttl_sum} = {1'b0, in_now_time} + {1'b0, in_time_to_live};

  // ---------------- state ----------------
  state_t      state_r, state_nxt;
  logic [PW-1:0] count_r, count_nxt;
  logic [36:0] byte_total_r, byte_total_nxt;
  logic [63:0] last_scan_r, last_scan_nxt;
  logic        dropped_r, dropped_nxt;
  logic        phase_enf_r, phase_enf_nxt; // scan during insert/get done
  logic [PW-1:0] pos_r, pos_nxt;
  // bit-serial remainder
  logic [PW:0]   rem_r, rem_nxt;
  logic [5:0]    bit_r, bit_nxt;

  cell_ctl_t   ctl;
  logic [PW-1:0] pop_pos;
  entry_t      push_entry;
  entry_t      entries [NCELL];
  logic [NCELL-1:0] valids, marks;

  tfkv_row #(.NCELL(NCELL), .PW(PW)) u_row (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .pop_pos(pop_pos),
    .now_time(now_r), .find_key(key_r), .push_entry(push_entry),
    .entries(entries), .valids(valids), .marks(marks)
  );

  // oldest marked cell
  logic          any_mark;
  logic [PW-1:0] mark_pos;
  always_comb begin
    any_mark = 1'b0;
    mark_pos = '0;
    for (int i = NCELL - 1; i >= 0; i--) begin
      if (marks[i]) begin
        any_mark = 1'b1;
        mark_pos = PW'(i);
      end
    end
  end

  // effective item limit
  logic [PW-1:0] eff_limit;
  assign eff_limit = (item_limit_r == 11'd0 || item_limit_r > 11'(CAPACITY))
                     ? PW'(CAPACITY) : item_limit_r[PW-1:0];

  logic over_limit;
  assign over_limit = (count_r != '0) &&
                      ((count_r > eff_limit) ||
                       (byte_limit_r != '0 && byte_total_r > 37'(byte_limit_r)));

  // scan-due test on the incoming item's time
  logic scan_due;
  assign scan_due = (scan_interval_r == '0) || (last_scan_r == '0) ||
                    ((in_now_time - last_scan_r) >= 64'(scan_interval_r));

  entry_t victim;
  assign victim = entries[pos_r];

  logic [PW:0] rem_sh;
  assign rem_sh = {rem_r[PW-1:0], draw_r[5'(bit_r)]};

  // ---------------- output register ----------------
  logic        ov_r;
  logic        kind_r, last_r;
  status_t     st_r;
  logic [63:0] okey_r;
  logic [31:0] oval_r, obytes_r;
  logic [5:0]  held_r;
  logic        emit;
  logic        ekind, elast;
  status_t     est;
  logic [63:0] ekey;
  logic [31:0] eval, ebytes;
  logic [PW-1:0] ecount;
  logic        busy;

  assign busy = ov_r && !out_ready;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    byte_total_nxt = byte_total_r;
    last_scan_nxt  = last_scan_r;
    dropped_nxt    = dropped_r;
    phase_enf_nxt  = phase_enf_r;
    pos_nxt        = pos_r;
    rem_nxt        = rem_r;
    bit_nxt        = bit_r;
    ctl            = '0;
    pop_pos        = pos_r;
    emit           = 1'b0;
    ekind          = 1'b0;
    elast          = 1'b0;
    est            = ST_OK;
    ekey           = '0;
    eval           = '0;
    ebytes         = '0;
    ecount         = count_r;
    push_entry.key    = key_r;
    push_entry.value  = val_r;
    push_entry.bytes  = bytes_r;
    push_entry.expiry = expiry_r;
    push_entry.fresh  = 1'b1;
    if (!busy) begin
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            dropped_nxt   = 1'b0;
            phase_enf_nxt = 1'b0;
            case (cmd_t'(in_cmd))
              CMD_INSERT, CMD_GET: begin
                if (scan_due) begin
                  last_scan_nxt = in_now_time;
                  state_nxt = S_EXP_MARK;
                end else begin
                  phase_enf_nxt = 1'b1;
                  state_nxt = S_KEY_MARK;
                end
              end
              CMD_DELETE: begin
                phase_enf_nxt = 1'b1;
                state_nxt = S_KEY_MARK;
              end
              default: state_nxt = S_EXP_MARK;
            endcase
          end
        end
        S_EXP_MARK: begin
          ctl.mark_expired = 1'b1;
          state_nxt = S_EXP_POP;
        end
        S_EXP_POP: begin
          if (any_mark) begin
            // a pop drops the marks of the shifted cells, so mark again
            pop_pos = mark_pos;
            ctl.pop = 1'b1;
            count_nxt = count_r - 1'b1;
            byte_total_nxt = byte_total_r - 37'(entries[mark_pos].bytes);
            emit = 1'b1;
            ekey = entries[mark_pos].key;
            eval = entries[mark_pos].value;
            ebytes = entries[mark_pos].bytes;
            ecount = count_nxt;
            state_nxt = S_EXP_MARK;
          end else begin
            state_nxt = S_ENF_CHECK;
          end
        end
        S_ENF_CHECK: begin
          if (over_limit) begin
            if (evict_policy_r) begin
              rem_nxt = '0;
              bit_nxt = 6'd31;
              state_nxt = S_ENF_MOD;
            end else begin
              pos_nxt = '0;
              state_nxt = S_ENF_POP;
            end
          end else if (cmd_r == CMD_SCAN) begin
            state_nxt = S_FINAL;
          end else if (cmd_r == CMD_INSERT && phase_enf_r) begin
            state_nxt = S_FINAL;
          end else begin
            phase_enf_nxt = 1'b1;
            ctl.mark_key = 1'b1;
            state_nxt = S_FIND;
          end
        end
        S_ENF_MOD: begin
          rem_nxt = (rem_sh >= {1'b0, count_r}) ? rem_sh - {1'b0, count_r} : rem_sh;
          bit_nxt = bit_r - 6'd1;
          if (bit_r == 6'd0) begin
            pos_nxt = rem_nxt[PW-1:0];
            state_nxt = S_ENF_POP;
          end
        end
        S_ENF_POP: begin
          ctl.pop = 1'b1;
          count_nxt = count_r - 1'b1;
          byte_total_nxt = byte_total_r - 37'(victim.bytes);
          if (victim.fresh) begin
            dropped_nxt = 1'b1;
          end else begin
            emit = 1'b1;
            ekey = victim.key;
            eval = victim.value;
            ebytes = victim.bytes;
            ecount = count_nxt;
          end
          state_nxt = S_ENF_CHECK;
        end
        S_KEY_MARK: begin
          ctl.mark_key = 1'b1;
          state_nxt = S_FIND;
        end
        S_FIND: begin
          case (cmd_r)
            CMD_INSERT: begin
              if (any_mark) begin
                dropped_nxt = 1'b0;
                emit = 1'b1; ekind = 1'b1; elast = 1'b1; est = ST_DUP;
              end else begin
                state_nxt = S_INS_PUSH;
              end
            end
            CMD_GET: begin
              if (!any_mark) begin
                emit = 1'b1; ekind = 1'b1; elast = 1'b1; est = ST_MISS;
              end else if (entries[mark_pos].expiry != '0 &&
                           entries[mark_pos].expiry <= now_r) begin
                pos_nxt = mark_pos;
                state_nxt = S_DEL_POP;
              end else begin
                emit = 1'b1; ekind = 1'b1; elast = 1'b1; est = ST_OK;
                eval = entries[mark_pos].value;
              end
            end
            CMD_DELETE: begin
              if (!any_mark) begin
                emit = 1'b1; ekind = 1'b1; elast = 1'b1; est = ST_NOTFOUND;
              end else begin
                pos_nxt = mark_pos;
                state_nxt = S_DEL_POP;
              end
            end
            default: state_nxt = S_FINAL;
          endcase
        end
        S_INS_PUSH: begin
          ctl.push = 1'b1;
          count_nxt = count_r + 1'b1;
          byte_total_nxt = byte_total_r + 37'(bytes_r);
          state_nxt = S_ENF_CHECK;
        end
        S_DEL_POP: begin
          ctl.pop = 1'b1;
          count_nxt = count_r - 1'b1;
          byte_total_nxt = byte_total_r - 37'(victim.bytes);
          emit = 1'b1;
          ekey = victim.key;
          eval = victim.value;
          ebytes = victim.bytes;
          ecount = count_nxt;
          state_nxt = S_FINAL;
        end
        S_FINAL: begin
          emit = 1'b1; ekind = 1'b1; elast = 1'b1;
          if (cmd_r == CMD_INSERT && dropped_r) begin
            est = ST_MISS; ekey = key_r; eval = val_r; ebytes = bytes_r;
          end else if (cmd_r == CMD_GET) begin
            est = ST_MISS;
          end else begin
            est = ST_OK;
          end
        end
        default: state_nxt = S_IDLE;
      endcase
      // a final status ends the item
      if (emit && elast) state_nxt = S_IDLE;
    end
    // fresh flag is cleared on all cells when the item ends
    if (state_r == S_IDLE) ctl.clear_marks = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      byte_total_r <= '0;
      last_scan_r  <= '0;
      dropped_r    <= 1'b0;
      phase_enf_r  <= 1'b0;
      pos_r        <= '0;
      rem_r        <= '0;
      bit_r        <= '0;
      ov_r         <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      byte_total_r <= byte_total_nxt;
      last_scan_r  <= last_scan_nxt;
      dropped_r    <= dropped_nxt;
      phase_enf_r  <= phase_enf_nxt;
      pos_r        <= pos_nxt;
      rem_r        <= rem_nxt;
      bit_r        <= bit_nxt;
      if (emit) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r    <= cmd_t'(in_cmd);
      key_r    <= in_lookup_key;
      val_r    <= in_value_handle;
      bytes_r  <= in_entry_bytes;
      now_r    <= in_now_time;
      draw_r   <= in_random_draw;
      expiry_r <= (in_time_to_live == '0) ? in_absolute_expiry :
                  (ttl_ovf ? 64'hFFFF_FFFF_FFFF_FFFF : ttl_sum);
    end
    if (emit) begin
      kind_r   <= ekind;
      st_r     <= est;
      okey_r   <= ekey;
      oval_r   <= eval;
      obytes_r <= ebytes;
      held_r   <= 6'(ecount);
      last_r   <= elast;
    end
  end

  assign in_ready = (state_r == S_IDLE) && !ov_r;

  assign out_valid        = ov_r;
  assign out_result_kind  = kind_r;
  assign out_status       = st_r;
  assign out_out_key      = okey_r;
  assign out_out_value    = oval_r;
  assign out_out_bytes    = obytes_r;
  assign out_entries_held = held_r;
  assign out_last         = last_r;

  // ---------------- assertions ----------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= PW'(NCELL)) else $error("entry count above cell count");
  a_count_valids: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valids) == int'(count_r)) else $error("count differs from valid cells");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r != S_IDLE) else $error("item accepted without work");
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(count_r)) else $error("state moved during stall");

endmodule
`default_nettype wire

/* hw/rtl/tfkv_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfkv_cell: one storage cell of the entry row
// Holds one entry and its valid bit. On a removal at or below its position
// the cell takes the entry of its younger neighbor; a push fills the first
// empty cell. Cells also flag expiry and key matches for the sequencer.
// ----------------------------------------------------------------------------
module tfkv_cell
  import tfkv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cell_ctl_t   ctl,
  input  wire logic [63:0] now_time,
  input  wire logic [63:0] find_key,
  input  wire entry_t      push_entry,
  input  wire logic        shift_in,      // this cell or an older one is removed
  input  wire logic        prev_valid,    // older neighbor is valid
  input  wire entry_t      next_entry,    // younger neighbor
  input  wire logic        next_valid,
  output entry_t           entry,
  output logic             valid,
  output logic             mark
);

  entry_t ent_r;
  logic   valid_r, valid_nxt;
  logic   mark_r, mark_nxt;
  logic   expired;

  assign expired = (ent_r.expiry != 64'd0) && (ent_r.expiry <= now_time);

  always_comb begin
    valid_nxt = valid_r;
    mark_nxt  = mark_r;
    if (ctl.clear_marks) mark_nxt = 1'b0;
    if (ctl.mark_expired) mark_nxt = valid_r && expired;
    if (ctl.mark_key) mark_nxt = valid_r && (ent_r.key == find_key);
    if (ctl.pop && shift_in) begin
      valid_nxt = next_valid;
      mark_nxt  = 1'b0;
    end
    if (ctl.push && !valid_r && prev_valid) valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      mark_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      mark_r  <= mark_nxt;
    end
  end

  // the fresh flag only lives for the item that pushed the entry
  always_ff @(posedge clk) begin
    if (ctl.pop && shift_in) ent_r <= next_entry;
    else if (ctl.push && !valid_r && prev_valid) ent_r <= push_entry;
    else if (ctl.clear_marks) ent_r.fresh <= 1'b0;
  end

  assign entry = ent_r;
  assign valid = valid_r;
  assign mark  = mark_r;

endmodule
`default_nettype wire

/* hw/rtl/tfkv_row.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfkv_row: chain of entry cells
// CAPACITY+1 cells in age order, oldest at position 0. Removal at a
// position shifts every younger entry one cell toward the head.
// ----------------------------------------------------------------------------
module tfkv_row
  import tfkv_pkg::*;
#(
  parameter int NCELL = 17,
  parameter int PW    = 5
)
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cell_ctl_t     ctl,
  input  wire logic [PW-1:0] pop_pos,
  input  wire logic [63:0]   now_time,
  input  wire logic [63:0]   find_key,
  input  wire entry_t        push_entry,
  output entry_t             entries [NCELL],
  output logic [NCELL-1:0]   valids,
  output logic [NCELL-1:0]   marks
);

  entry_t zero_entry;
  assign zero_entry = '0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic   pv, nv, sh;
    entry_t ne;
    assign sh = (PW'(i) >= pop_pos);
    if (i == 0) begin : g_head
      assign pv = 1'b1;
    end else begin : g_body
      assign pv = valids[i-1];
    end
    if (i == NCELL - 1) begin : g_tail
      assign ne = zero_entry;
      assign nv = 1'b0;
    end else begin : g_mid
      assign ne = entries[i+1];
      assign nv = valids[i+1];
    end
    tfkv_cell u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .now_time(now_time),
      .find_key(find_key), .push_entry(push_entry), .shift_in(sh),
      .prev_valid(pv), .next_entry(ne), .next_valid(nv),
      .entry(entries[i]), .valid(valids[i]), .mark(marks[i])
    );
  end

endmodule
`default_nettype wire

/* tb/sv/tb_ttl_fifo_key_value_cache.sv */
// ----------------------------------------------------------------------------
// tb_ttl_fifo_key_value_cache: self-checking bench for the expiring cache
// Items go in from a queue through a valid/ready driver. An in-bench model of
// the cache works out the removal notices and the final status of each
// accepted item, and a monitor checks every result against them. The run
// goes through several register settings and uses random stalls on both
// sides, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_ttl_fifo_key_value_cache;
  import tfkv_pkg::*;

  localparam int CAP       = 16;
  localparam int WDOG_MAX  = 4000;

  typedef struct {
    cmd_t        cmd;
    logic [63:0] key;
    logic [31:0] value;
    logic [31:0] nbytes;
    logic [63:0] ttl;
    logic [63:0] abs_exp;
    logic [63:0] now;
    logic [31:0] draw;
  } cache_op_t;

  typedef struct {
    logic        kind;
    status_t     status;
    logic [63:0] key;
    logic [31:0] value;
    logic [31:0] nbytes;
    logic [5:0]  held;
    logic        last;
  } cache_res_t;

  typedef struct {
    logic [63:0] key;
    logic [31:0] value;
    logic [31:0] nbytes;
    logic [63:0] expiry;
    logic        fresh;
  } cache_ent_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_cmd = '0;
  logic [63:0] in_lookup_key = '0;
  logic [31:0] in_value_handle = '0;
  logic [31:0] in_entry_bytes = '0;
  logic [63:0] in_time_to_live = '0;
  logic [63:0] in_absolute_expiry = '0;
  logic [63:0] in_now_time = '0;
  logic [31:0] in_random_draw = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_result_kind;
  logic [1:0]  out_status;
  logic [63:0] out_out_key;
  logic [31:0] out_out_value;
  logic [31:0] out_out_bytes;
  logic [5:0]  out_entries_held;
  logic        out_last;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  ttl_fifo_key_value_cache #(.CAPACITY(CAP)) DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // model state
  cache_ent_t  cache_q[$];
  logic [63:0] bytes_sum;
  logic [63:0] last_scan;
  logic [10:0] m_item_limit;
  logic [35:0] m_byte_limit;
  logic [31:0] m_scan_intvl;
  logic        m_policy;

  cache_op_t   pending_ops[$];
  cache_res_t  expected_res[$];
  cache_op_t   cur_op;
  int          err_count = 0;
  int          rx_hold = 0;
  bit          no_idle = 0;
  logic [63:0] key_pool[20];
  logic [63:0] now_ms;

  function automatic void expect_res(logic kind, status_t st, logic [63:0] k,
                                     logic [31:0] v, logic [31:0] b, logic lst);
    cache_res_t r;
    r.kind = kind; r.status = st; r.key = k; r.value = v; r.nbytes = b;
    r.held = 6'(cache_q.size()); r.last = lst;
    expected_res.push_back(r);
  endfunction

  function automatic void drop_with_notice(int pos);
    cache_ent_t e;
    e = cache_q[pos];
    bytes_sum -= e.nbytes;
    cache_q.delete(pos);
    expect_res(1'b0, ST_OK, e.key, e.value, e.nbytes, 1'b0);
  endfunction

  function automatic bit is_expired(cache_ent_t e, logic [63:0] now);
    return e.expiry != 0 && e.expiry <= now;
  endfunction

  function automatic void sweep_expired(logic [63:0] now);
    int pos;
    pos = 0;
    while (pos < cache_q.size()) begin
      if (is_expired(cache_q[pos], now)) drop_with_notice(pos);
      else pos++;
    end
  endfunction

  // evict until limits hold; returns 1 if the fresh entry itself went
  function automatic bit trim_to_limits(logic [31:0] draw, output cache_ent_t gone);
    int eff, pos;
    bit dropped;
    eff = (m_item_limit == 0 || m_item_limit > CAP) ? CAP : int'(m_item_limit);
    dropped = 0;
    gone = '{default: '0};
    while (cache_q.size() > eff || (m_byte_limit != 0 && bytes_sum > m_byte_limit)) begin
      if (cache_q.size() == 0) break;
      pos = m_policy ? int'(draw % 32'(cache_q.size())) : 0;
      if (cache_q[pos].fresh) begin
        gone = cache_q[pos];
        dropped = 1;
        bytes_sum -= gone.nbytes;
        cache_q.delete(pos);
      end else begin
        drop_with_notice(pos);
      end
    end
    return dropped;
  endfunction

  function automatic void scan_if_due(logic [63:0] now, logic [31:0] draw);
    cache_ent_t g;
    if (m_scan_intvl == 0 || last_scan == 0 || (now - last_scan) >= {32'd0, m_scan_intvl}) begin
      last_scan = now;
      sweep_expired(now);
      void'(trim_to_limits(draw, g));
    end
  endfunction

  function automatic int find_key(logic [63:0] k);
    foreach (cache_q[i]) if (cache_q[i].key == k) return i;
    return -1;
  endfunction

  function automatic void predict_cache(cache_op_t op);
    cache_ent_t e, g;
    int pos;
    case (op.cmd)
      CMD_INSERT: begin
        scan_if_due(op.now, op.draw);
        if (find_key(op.key) >= 0) begin
          expect_res(1'b1, ST_DUP, '0, '0, '0, 1'b1);
        end else if (cache_q.size() >= CAP + 1) begin
          expect_res(1'b1, ST_MISS, op.key, op.value, op.nbytes, 1'b1);
        end else begin
          e.key = op.key; e.value = op.value; e.nbytes = op.nbytes; e.fresh = 1'b1;
          if (op.ttl != 0)
            e.expiry = (op.ttl > ~op.now) ? '1 : op.now + op.ttl;
          else
            e.expiry = op.abs_exp;
          cache_q.push_back(e);
          bytes_sum += op.nbytes;
          if (trim_to_limits(op.draw, g)) begin
            expect_res(1'b1, ST_MISS, g.key, g.value, g.nbytes, 1'b1);
          end else begin
            cache_q[cache_q.size()-1].fresh = 1'b0;
            expect_res(1'b1, ST_OK, '0, '0, '0, 1'b1);
          end
        end
      end
      CMD_GET: begin
        scan_if_due(op.now, op.draw);
        pos = find_key(op.key);
        if (pos < 0) begin
          expect_res(1'b1, ST_MISS, '0, '0, '0, 1'b1);
        end else if (is_expired(cache_q[pos], op.now)) begin
          drop_with_notice(pos);
          expect_res(1'b1, ST_MISS, '0, '0, '0, 1'b1);
        end else begin
          expect_res(1'b1, ST_OK, '0, cache_q[pos].value, '0, 1'b1);
        end
      end
      CMD_DELETE: begin
        pos = find_key(op.key);
        if (pos < 0) begin
          expect_res(1'b1, ST_NOTFOUND, '0, '0, '0, 1'b1);
        end else begin
          drop_with_notice(pos);
          expect_res(1'b1, ST_OK, '0, '0, '0, 1'b1);
        end
      end
      default: begin
        sweep_expired(op.now);
        void'(trim_to_limits(op.draw, g));
        expect_res(1'b1, ST_OK, '0, '0, '0, 1'b1);
      end
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) predict_cache(cur_op);
      if (pending_ops.size() > 0 && (no_idle || $urandom_range(0, 99) >= 33)) begin
        cur_op = pending_ops.pop_front();
        in_valid           <= 1'b1;
        in_cmd             <= cur_op.cmd;
        in_lookup_key      <= cur_op.key;
        in_value_handle    <= cur_op.value;
        in_entry_bytes     <= cur_op.nbytes;
        in_time_to_live    <= cur_op.ttl;
        in_absolute_expiry <= cur_op.abs_exp;
        in_now_time        <= cur_op.now;
        in_random_draw     <= cur_op.draw;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
      err_count++;
    end
  endfunction

  // monitor
  always @(posedge clk) begin
    cache_res_t r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected result: expected none, got kind %b key %h", $time,
                 out_result_kind, out_out_key);
        err_count++;
      end else begin
        r = expected_res.pop_front();
        check_field("result_kind", 64'(r.kind), 64'(out_result_kind));
        check_field("status", 64'(r.status), 64'(out_status));
        check_field("out_key", r.key, out_out_key);
        check_field("out_value", 64'(r.value), 64'(out_out_value));
        check_field("out_bytes", 64'(r.nbytes), 64'(out_out_bytes));
        check_field("entries_held", 64'(r.held), 64'(out_entries_held));
        check_field("last", 64'(r.last), 64'(out_last));
      end
    end
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || $urandom_range(0, 99) >= 33;
    end
  end

  // watchdog: cycles with no handshake on any port
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_psel && cfg_penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("tb_ttl_fifo_key_value_cache: FAIL");
      $finish;
    end
  end

  task automatic cfg_write(reg_idx_t idx, logic [63:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= 5'(idx) << 3; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_ITEM_LIMIT: m_item_limit = v[10:0];
      REG_BYTE_LIMIT: m_byte_limit = v[35:0];
      REG_SCAN_INTVL: m_scan_intvl = v[31:0];
      REG_EVICT_POL:  m_policy = v[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [63:0] lim, logic [63:0] blim, logic [63:0] intvl,
                            logic [63:0] pol);
    cfg_write(REG_ITEM_LIMIT, lim);
    cfg_write(REG_BYTE_LIMIT, blim);
    cfg_write(REG_SCAN_INTVL, intvl);
    cfg_write(REG_EVICT_POL, pol);
  endtask

  task automatic drain;
    while (pending_ops.size() > 0 || in_valid || expected_res.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void add_op(cmd_t c, logic [63:0] k, logic [31:0] v, logic [31:0] b,
                                 logic [63:0] ttl, logic [63:0] ax, logic [63:0] now,
                                 logic [31:0] d);
    cache_op_t op;
    op.cmd = c; op.key = k; op.value = v; op.nbytes = b;
    op.ttl = ttl; op.abs_exp = ax; op.now = now; op.draw = d;
    pending_ops.push_back(op);
  endfunction

  function automatic void add_random_op(int max_bytes);
    int sel;
    logic [63:0] k, ttl, ax;
    logic [31:0] b;
    sel = $urandom_range(0, 99);
    now_ms += 64'($urandom_range(0, 40));
    if ($urandom_range(0, 49) == 0) now_ms = rand64();
    k = ($urandom_range(0, 9) == 0) ? rand64() : key_pool[$urandom_range(0, 19)];
    b = ($urandom_range(0, 19) == 0) ? $urandom : 32'($urandom_range(0, max_bytes));
    ttl = '0;
    ax = '0;
    case ($urandom_range(0, 4))
      0: ttl = 64'($urandom_range(1, 120));
      1: ax = now_ms + 64'($urandom_range(0, 120));
      2: ttl = rand64();
      3: ax = rand64();
      default: ;
    endcase
    add_op(sel < 50 ? CMD_INSERT : sel < 80 ? CMD_GET : sel < 93 ? CMD_DELETE : CMD_SCAN,
           k, $urandom, b, ttl, ax, now_ms, $urandom);
  endfunction

  task automatic random_phase(int n, int max_bytes);
    repeat (n) add_random_op(max_bytes);
  endtask

  initial begin
    cache_q.delete();
    bytes_sum = 0; last_scan = 0;
    m_item_limit = 0; m_byte_limit = 0; m_scan_intvl = 0; m_policy = 0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 20; i++) key_pool[i] = rand64();
    now_ms = 100;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, scan on every insert or get
    add_op(CMD_INSERT, '0, '1, '1, '0, '0, 64'd10, '1);
    add_op(CMD_INSERT, '1, 32'h1234, 32'd8, '1, '0, 64'd20, '0);  // saturating expiry
    add_op(CMD_INSERT, '0, 32'h5, 32'd1, '0, '0, 64'd21, '0);     // duplicate key
    add_op(CMD_GET, '0, '0, '0, '0, '0, 64'd22, '0);
    add_op(CMD_GET, 64'hdead, '0, '0, '0, '0, 64'd23, '0);
    add_op(CMD_DELETE, 64'hbeef, '0, '0, '0, '0, 64'd24, '0);
    add_op(CMD_DELETE, '0, '0, '0, '0, '0, 64'd25, '0);
    add_op(CMD_INSERT, 64'd5, 32'd7, 32'd3, '0, 64'd30, 64'd26, '0);
    add_op(CMD_INSERT, 64'd6, 32'd8, 32'd4, 64'd5, '0, 64'd27, '0);
    add_op(CMD_GET, 64'd5, '0, '0, '0, '0, 64'd30, '0);           // expired, swept by scan
    add_op(CMD_SCAN, '0, '0, '0, '0, '0, '1, '1);                 // forced scan at max time
    add_op(CMD_INSERT, 64'd9, 32'd9, 32'd9, '0, '0, '1, '0);
    drain();

    // small item limit, oldest-first eviction, with a long receiver hold-off
    set_config(3, 0, 1000, 0);
    add_op(CMD_INSERT, 64'd70, 32'd1, 32'd1, '0, now_ms + 5, now_ms, '0);
    add_op(CMD_GET, 64'd70, '0, '0, '0, '0, now_ms + 10, '0);     // expired entry on get
    rx_hold = 400;
    random_phase(70, 100);
    drain();

    // byte limit with random victims, no idling on either side
    set_config(0, 200, 0, 1);
    no_idle = 1;
    random_phase(70, 80);
    drain();
    no_idle = 0;

    // registers at their maximum
    set_config(2047, 64'hF_FFFF_FFFF, 64'hFFFF_FFFF, 1);
    add_op(CMD_INSERT, 64'd71, 32'd2, 32'd2, '0, now_ms + 1, now_ms, '0);
    add_op(CMD_GET, 64'd71, '0, '0, '0, '0, now_ms + 3, '0);
    random_phase(70, 1000);
    drain();

    // tiny budgets: new entries are often dropped right away
    set_config(1, 1, 0, 0);
    random_phase(60, 3);
    drain();

    set_config(1024, 500, 7, 1);
    random_phase(70, 200);
    drain();

    if (err_count == 0)
      $display("tb_ttl_fifo_key_value_cache: PASS");
    else
      $display("tb_ttl_fifo_key_value_cache: FAIL");
    $finish;
  end

endmodule
